### hw/rtl/tte_pkg.sv
package tte_pkg;

	localparam int TTE_BUF_ROWS = 100;
	localparam int TTE_BUF_COLS = 256;

	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_ESC   = 8'd27;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CMD_UP      = 8'h41;
	localparam logic [7:0] CMD_DOWN    = 8'h42;
	localparam logic [7:0] CMD_RIGHT   = 8'h43;
	localparam logic [7:0] CMD_LEFT    = 8'h44;
	localparam logic [7:0] CMD_CLEAR   = 8'h45;
	localparam logic [7:0] CMD_HOME    = 8'h48;
	localparam logic [7:0] CMD_CLR_EOS = 8'h4A;
	localparam logic [7:0] CMD_INS_ON  = 8'h51;
	localparam logic [7:0] CMD_INS_OFF = 8'h52;
	localparam logic [7:0] CMD_WIN_DN  = 8'h53;
	localparam logic [7:0] CMD_WIN_UP  = 8'h54;
	localparam logic [7:0] CMD_HIDE    = 8'h3C;
	localparam logic [7:0] CMD_SHOW    = 8'h3E;
	localparam logic [7:0] CMD_ADDR    = 8'h25;

	localparam logic [1:0] CFG_VIEW_ROWS = 2'd0;
	localparam logic [1:0] CFG_VIEW_COLS = 2'd1;
	localparam logic [1:0] CFG_CHARSET   = 2'd2;

	localparam logic [1:0] PH_NONE = 2'd0;
	localparam logic [1:0] PH_COL  = 2'd1;
	localparam logic [1:0] PH_ROW  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MOD,
		ST_FILL,
		ST_JCLR
	} state_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
		logic [6:0] read_row;
		logic [7:0] read_col;
	} tte_in_t;

	typedef struct packed {
		logic [7:0] cell_char;
		logic [7:0] cursor_col;
		logic [6:0] cursor_row;
		logic [6:0] window_top;
		logic [4:0] status_byte;
	} tte_out_t;

	typedef struct packed {
		logic start;
	} mod_ctl_t;

	function automatic logic [6:0] follow(input logic [6:0] line, input logic [6:0] top,
		input logic [7:0] vr);
		logic [7:0] lim;
		logic [7:0] nt;
		lim = {1'b0, top} + vr;
		nt = {1'b0, line} - vr + 8'd1;
		if (line < top) begin
			return line;
		end else if ({1'b0, line} >= lim) begin
			return nt[6:0];
		end
		return top;
	endfunction

endpackage

### hw/rtl/tte_mod.sv
module tte_mod (
	input  logic                clk,
	input  logic                arst_n,
	input  tte_pkg::mod_ctl_t   ctl_in,
	output logic                done,
	input  logic [7:0]          num,
	input  logic [8:0]          den,
	output logic [7:0]          rem
);

	logic       run_q;
	logic [3:0] cnt_q;
	logic [8:0] r_q;
	logic [7:0] n_q;
	logic [8:0] trial;

	assign trial = {r_q[7:0], n_q[7]};
	assign done  = run_q && (cnt_q == 4'd0);
	assign rem   = r_q[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= 4'd0;
		end else if (ctl_in.start) begin
			run_q <= 1'b1;
			cnt_q <= 4'd8;
		end else if (done) begin
			run_q <= 1'b0;
		end else if (run_q) begin
			cnt_q <= cnt_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			r_q <= 9'd0;
			n_q <= num;
		end else if (run_q && cnt_q != 4'd0) begin
			r_q <= (trial >= den) ? trial - den : trial;
			n_q <= {n_q[6:0], 1'b0};
		end
	end

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> r_q < den) else $error("remainder not below divisor");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_in.start |-> !run_q || done) else $error("divider restarted mid run");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("divider done longer than one cycle");

endmodule

### hw/rtl/text_terminal_escape_engine_unit.sv
// Terminal byte engine: start with busy low takes one beat (a received byte or a cell read)
// and done marks exactly one result beat that cannot be held off. A cell read goes through
// ST_READ; column/row address bytes wait in ST_MOD for the 8-step remainder unit.
// A row that is still blank after reset, a clear, a scroll or a view size write is swept
// to spaces in ST_FILL when its first character is written; ESC J clears the cursor row
// from the cursor column in ST_JCLR. Clears and scrolls otherwise use per-row valid bits
// and a rotating row offset, so no clearing pass follows reset.
module text_terminal_escape_engine_unit #(
	parameter int BUF_ROWS = tte_pkg::TTE_BUF_ROWS,
	parameter int BUF_COLS = tte_pkg::TTE_BUF_COLS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  tte_pkg::tte_in_t  req,
	output logic              done,
	output tte_pkg::tte_out_t rsp,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [8:0]        cfg_data
);

	localparam int DEPTH = BUF_ROWS * BUF_COLS;
	localparam int AW = $clog2(DEPTH);
	localparam int RIW = $clog2(BUF_ROWS);
	localparam logic [7:0] ROWS8 = 8'(BUF_ROWS);
	localparam logic [8:0] COLS9 = 9'(BUF_COLS);
	localparam logic [7:0] VR_RST = (BUF_ROWS < 24) ? 8'(BUF_ROWS) : 8'd24;
	localparam logic [8:0] VC_RST = (BUF_COLS < 80) ? 9'(BUF_COLS) : 9'd80;

	tte_pkg::state_t state_q, state_n;

	logic [7:0] col_q, col_n;
	logic [6:0] line_q, line_n;
	logic [6:0] top_q, top_n;
	logic [6:0] off_q, off_n;
	logic       esc_q, esc_n;
	logic [1:0] phase_q, phase_n;
	logic       ins_q, ins_n;
	logic       hid_q, hid_n;
	logic [7:0] vr_q;
	logic [8:0] vc_q;
	logic       r8_q;
	logic [7:0] cell_q, cell_n;
	logic       done_q, done_n;
	logic [8:0] sweep_q, sweep_n;
	logic [7:0] byte_q;
	logic       oob_q;
	logic       rvalid_q;
	logic [BUF_ROWS-1:0] valid_q;

	logic [7:0] mem [DEPTH];
	logic [7:0] mem_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic [AW-1:0] mem_raddr;

	logic clr_all, clr_below, scroll, set_valid;
	logic cfg_size;
	logic [6:0] cur_prow;
	logic [6:0] rd_prow;
	logic       rd_oob;
	logic       row_ok;
	logic [8:0] col_inc;
	logic [8:0] sweep_inc;

	tte_pkg::mod_ctl_t mod_ctl;
	logic       mod_done;
	logic [7:0] mod_rem;
	logic [8:0] mod_den;
	logic [7:0] top_plus;

	function automatic logic [6:0] phys(input logic [6:0] l, input logic [6:0] off);
		logic [7:0] s;
		s = {1'b0, l} + {1'b0, off};
		if (s >= ROWS8) begin
			s = s - ROWS8;
		end
		return s[6:0];
	endfunction

	function automatic logic [AW-1:0] addr(input logic [6:0] prow, input logic [7:0] col);
		return AW'(prow) * AW'(BUF_COLS) + AW'(col);
	endfunction

	assign cur_prow  = phys(line_q, off_q);
	assign rd_oob    = ({1'b0, req.read_row} >= ROWS8) || ({1'b0, req.read_col} >= COLS9);
	assign rd_prow   = phys(rd_oob ? 7'd0 : req.read_row, off_q);
	assign mem_raddr = addr(rd_prow, rd_oob ? 8'd0 : req.read_col);
	assign row_ok    = valid_q[cur_prow[RIW-1:0]];
	assign col_inc   = {1'b0, col_q} + 9'd1;
	assign sweep_inc = sweep_q + 9'd1;
	assign cfg_size  = cfg_we && (cfg_index == tte_pkg::CFG_VIEW_ROWS ||
		cfg_index == tte_pkg::CFG_VIEW_COLS);
	assign mod_den   = (phase_q == tte_pkg::PH_COL) ? vc_q : {1'b0, vr_q};
	assign top_plus  = {1'b0, top_q} + mod_rem;

	tte_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_in (mod_ctl),
		.done   (mod_done),
		.num    (req.data_byte),
		.den    (mod_den),
		.rem    (mod_rem)
	);

	always_comb begin
		state_n   = state_q;
		col_n     = col_q;
		line_n    = line_q;
		top_n     = top_q;
		off_n     = off_q;
		esc_n     = esc_q;
		phase_n   = phase_q;
		ins_n     = ins_q;
		hid_n     = hid_q;
		cell_n    = cell_q;
		done_n    = 1'b0;
		sweep_n   = sweep_q;
		mem_we    = 1'b0;
		mem_waddr = addr(cur_prow, col_q);
		mem_wdata = tte_pkg::CH_SPACE;
		clr_all   = 1'b0;
		clr_below = 1'b0;
		scroll    = 1'b0;
		set_valid = 1'b0;
		mod_ctl.start = 1'b0;
		unique case (state_q)
			tte_pkg::ST_IDLE: begin
				if (start) begin
					cell_n = 8'd0;
					if (req.mode) begin
						state_n = tte_pkg::ST_READ;
					end else if (phase_q != tte_pkg::PH_NONE) begin
						mod_ctl.start = 1'b1;
						state_n = tte_pkg::ST_MOD;
					end else if (esc_q) begin
						esc_n = 1'b0;
						done_n = 1'b1;
						unique case (req.data_byte)
							tte_pkg::CMD_UP: begin
								if (line_q != 7'd0) line_n = line_q - 7'd1;
								top_n = tte_pkg::follow(line_n, top_q, vr_q);
							end
							tte_pkg::CMD_DOWN: begin
								if ({1'b0, line_q} < ROWS8 - 8'd1) line_n = line_q + 7'd1;
								top_n = tte_pkg::follow(line_n, top_q, vr_q);
							end
							tte_pkg::CMD_RIGHT: begin
								if (col_inc >= vc_q) begin
									col_n = 8'd0;
									if ({1'b0, line_q} < ROWS8 - 8'd1) begin
										line_n = line_q + 7'd1;
									end else begin
										line_n = 7'd0;
									end
								end else begin
									col_n = col_inc[7:0];
								end
								top_n = tte_pkg::follow(line_n, top_q, vr_q);
							end
							tte_pkg::CMD_LEFT: begin
								if (col_q != 8'd0) begin
									col_n = col_q - 8'd1;
								end else if (line_q != 7'd0) begin
									line_n = line_q - 7'd1;
									col_n = 8'(vc_q - 9'd1);
								end
								top_n = tte_pkg::follow(line_n, top_q, vr_q);
							end
							tte_pkg::CMD_CLEAR: begin
								clr_all = 1'b1;
								col_n = 8'd0;
								line_n = 7'd0;
								top_n = 7'd0;
							end
							tte_pkg::CMD_HOME: begin
								col_n = 8'd0;
								line_n = 7'd0;
								top_n = tte_pkg::follow(7'd0, top_q, vr_q);
							end
							tte_pkg::CMD_CLR_EOS: begin
								clr_below = 1'b1;
								top_n = tte_pkg::follow(line_q, top_q, vr_q);
								if (row_ok) begin
									done_n = 1'b0;
									sweep_n = {1'b0, col_q};
									state_n = tte_pkg::ST_JCLR;
								end
							end
							tte_pkg::CMD_WIN_DN: begin
								if ({1'b0, top_q} + vr_q < ROWS8) top_n = top_q + 7'd1;
								top_n = tte_pkg::follow(line_q, top_n, vr_q);
							end
							tte_pkg::CMD_WIN_UP: begin
								if (top_q != 7'd0) top_n = top_q - 7'd1;
								top_n = tte_pkg::follow(line_q, top_n, vr_q);
							end
							tte_pkg::CMD_INS_ON:  ins_n = 1'b1;
							tte_pkg::CMD_INS_OFF: ins_n = 1'b0;
							tte_pkg::CMD_HIDE:    hid_n = 1'b1;
							tte_pkg::CMD_SHOW:    hid_n = 1'b0;
							tte_pkg::CMD_ADDR:    phase_n = tte_pkg::PH_COL;
							default: ;
						endcase
					end else begin
						done_n = 1'b1;
						unique case (req.data_byte)
							tte_pkg::CH_ESC: esc_n = 1'b1;
							tte_pkg::CH_CR: begin
								col_n = 8'd0;
								top_n = tte_pkg::follow(line_q, top_q, vr_q);
							end
							tte_pkg::CH_LF: begin
								if ({1'b0, line_q} < ROWS8 - 8'd1) begin
									line_n = line_q + 7'd1;
								end else begin
									scroll = 1'b1;
									off_n = ({1'b0, off_q} + 8'd1 >= ROWS8) ? 7'd0
										: off_q + 7'd1;
								end
								top_n = tte_pkg::follow(line_n, top_q, vr_q);
							end
							tte_pkg::CH_NUL: begin
								top_n = tte_pkg::follow(line_q, top_q, vr_q);
							end
							default: begin
								if (row_ok) begin
									mem_we = 1'b1;
									mem_wdata = req.data_byte;
									if (col_inc >= vc_q) begin
										col_n = 8'd0;
										if ({1'b0, line_q} < ROWS8 - 8'd1) begin
											line_n = line_q + 7'd1;
										end
									end else begin
										col_n = col_inc[7:0];
									end
									top_n = tte_pkg::follow(line_n, top_q, vr_q);
								end else begin
									done_n = 1'b0;
									sweep_n = 9'd0;
									state_n = tte_pkg::ST_FILL;
								end
							end
						endcase
					end
				end
			end
			tte_pkg::ST_READ: begin
				cell_n = oob_q ? 8'd0 : (rvalid_q ? mem_q : tte_pkg::CH_SPACE);
				done_n = 1'b1;
				state_n = tte_pkg::ST_IDLE;
			end
			tte_pkg::ST_MOD: begin
				if (mod_done) begin
					if (phase_q == tte_pkg::PH_COL) begin
						col_n = mod_rem;
						phase_n = tte_pkg::PH_ROW;
					end else begin
						line_n = top_plus[6:0];
						phase_n = tte_pkg::PH_NONE;
					end
					done_n = 1'b1;
					state_n = tte_pkg::ST_IDLE;
				end
			end
			tte_pkg::ST_FILL: begin
				mem_we = 1'b1;
				mem_waddr = addr(cur_prow, sweep_q[7:0]);
				mem_wdata = (sweep_q[7:0] == col_q) ? byte_q : tte_pkg::CH_SPACE;
				sweep_n = sweep_inc;
				if (sweep_inc >= COLS9) begin
					set_valid = 1'b1;
					if (col_inc >= vc_q) begin
						col_n = 8'd0;
						if ({1'b0, line_q} < ROWS8 - 8'd1) line_n = line_q + 7'd1;
					end else begin
						col_n = col_inc[7:0];
					end
					top_n = tte_pkg::follow(line_n, top_q, vr_q);
					done_n = 1'b1;
					state_n = tte_pkg::ST_IDLE;
				end
			end
			tte_pkg::ST_JCLR: begin
				if (sweep_q < vc_q) begin
					mem_we = 1'b1;
					mem_waddr = addr(cur_prow, sweep_q[7:0]);
				end
				sweep_n = sweep_inc;
				if (sweep_inc >= vc_q) begin
					done_n = 1'b1;
					state_n = tte_pkg::ST_IDLE;
				end
			end
			default: state_n = tte_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tte_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= 8'd0;
			line_q  <= 7'd0;
			top_q   <= 7'd0;
			off_q   <= 7'd0;
			esc_q   <= 1'b0;
			phase_q <= tte_pkg::PH_NONE;
			ins_q   <= 1'b0;
			hid_q   <= 1'b0;
			vr_q    <= VR_RST;
			vc_q    <= VC_RST;
			r8_q    <= 1'b1;
			done_q  <= 1'b0;
			sweep_q <= 9'd0;
			cell_q  <= 8'd0;
			valid_q <= '0;
		end else begin
			esc_q   <= esc_n;
			phase_q <= phase_n;
			ins_q   <= ins_n;
			hid_q   <= hid_n;
			done_q  <= done_n;
			sweep_q <= sweep_n;
			cell_q  <= cell_n;
			off_q   <= off_n;
			if (cfg_size) begin
				col_q  <= 8'd0;
				line_q <= 7'd0;
				top_q  <= 7'd0;
			end else begin
				col_q  <= col_n;
				line_q <= line_n;
				top_q  <= top_n;
			end
			if (cfg_we && cfg_index == tte_pkg::CFG_VIEW_ROWS) begin
				if (cfg_data[6:0] == 7'd0) begin
					vr_q <= 8'd1;
				end else if ({1'b0, cfg_data[6:0]} > ROWS8) begin
					vr_q <= ROWS8;
				end else begin
					vr_q <= {1'b0, cfg_data[6:0]};
				end
			end
			if (cfg_we && cfg_index == tte_pkg::CFG_VIEW_COLS) begin
				if (cfg_data == 9'd0) begin
					vc_q <= 9'd1;
				end else if (cfg_data > COLS9) begin
					vc_q <= COLS9;
				end else begin
					vc_q <= cfg_data;
				end
			end
			if (cfg_we && cfg_index == tte_pkg::CFG_CHARSET) begin
				r8_q <= cfg_data[0];
			end
			if (clr_all || cfg_size) begin
				valid_q <= '0;
			end else begin
				for (int p = 0; p < BUF_ROWS; p++) begin
					if (clr_below && (((p >= int'(off_q)) ? p - int'(off_q)
						: p + BUF_ROWS - int'(off_q)) > int'(line_q))) begin
						valid_q[p] <= 1'b0;
					end
				end
				if (scroll) valid_q[off_q[RIW-1:0]] <= 1'b0;
				if (set_valid) valid_q[cur_prow[RIW-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tte_pkg::ST_IDLE && start) begin
			byte_q   <= req.data_byte;
			oob_q    <= rd_oob;
			rvalid_q <= valid_q[rd_prow[RIW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_q <= mem[mem_raddr];
	end

	assign busy = (state_q != tte_pkg::ST_IDLE);
	assign done = done_q;
	assign rsp.cell_char   = cell_q;
	assign rsp.cursor_col  = col_q;
	assign rsp.cursor_row  = line_q;
	assign rsp.window_top  = top_q;
	assign rsp.status_byte = {ins_q, hid_q, 1'b0, r8_q, 1'b0};

	a_col_in_view: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, col_q} < vc_q) else $error("cursor column outside view");
	a_row_in_buf: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, line_q} < ROWS8) else $error("cursor row outside buffer");
	a_fill_blank_row: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tte_pkg::ST_FILL |-> !row_ok) else $error("sweep over a live row");
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start)) else $error("result beat without work");

endmodule
